@@ rtl/chd_pkg.sv @@
package chd_pkg;

	// Largest number of hex characters in one chunk-size field.
	localparam int unsigned SIZE_DIGITS = 4;

	// Width of the digit counter; it holds 0 .. SIZE_DIGITS-1.
	localparam int unsigned DIGIT_W = (SIZE_DIGITS > 1) ? $clog2(SIZE_DIGITS) : 1;

	localparam int unsigned SIZE_W = 16;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned SKIP_W = 2;

	localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

	// Skip lengths after the size field and for the chunk trailer.
	localparam logic [SKIP_W-1:0] SKIP_AFTER_CR = 2'd1;
	localparam logic [SKIP_W-1:0] SKIP_NO_CR    = 2'd2;
	localparam logic [SKIP_W-1:0] SKIP_TRAILER  = 2'd2;

	typedef enum logic [2:0] {
		PH_SIZE  = 3'd0,
		PH_SKIP  = 3'd1,
		PH_DATA  = 3'd2,
		PH_TRAIL = 3'd3,
		PH_DONE  = 3'd4
	} phase_t;

	// What the decoder core makes of the word that it is offered.
	typedef struct packed {
		logic              emit;
		logic [BYTE_W-1:0] data;
		logic              eob;
	} chd_result_t;

	// Value of one hex character; anything that is not hex counts as zero.
	function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

endpackage

@@ rtl/chd_core.sv @@
module chd_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [chd_pkg::BYTE_W-1:0] in_byte,
	output chd_pkg::chd_result_t       result
);
	import chd_pkg::*;

	phase_t              phase_q, phase_d;
	logic [DIGIT_W-1:0]  digit_count_q, digit_count_d;
	logic [SIZE_W-1:0]   size_accum_q, size_accum_d;
	logic [SIZE_W-1:0]   bytes_left_q, bytes_left_d;
	logic [SKIP_W-1:0]   skip_left_q, skip_left_d;
	logic                last_chunk_q, last_chunk_d;

	logic [DIGIT_W:0]    digit_next;
	logic [SKIP_W-1:0]   skip_dec;
	logic [SIZE_W-1:0]   bytes_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SIZE;
			digit_count_q <= '0;
			size_accum_q  <= '0;
			bytes_left_q  <= '0;
			skip_left_q   <= '0;
			last_chunk_q  <= 1'b0;
		end else if (step) begin
			phase_q       <= phase_d;
			digit_count_q <= digit_count_d;
			size_accum_q  <= size_accum_d;
			bytes_left_q  <= bytes_left_d;
			skip_left_q   <= skip_left_d;
			last_chunk_q  <= last_chunk_d;
		end
	end

	assign digit_next = {1'b0, digit_count_q} + {{DIGIT_W{1'b0}}, 1'b1};
	assign skip_dec   = skip_left_q - {{(SKIP_W-1){1'b0}}, 1'b1};
	assign bytes_dec  = bytes_left_q - {{(SIZE_W-1){1'b0}}, 1'b1};

	always_comb begin
		phase_d       = phase_q;
		digit_count_d = digit_count_q;
		size_accum_d  = size_accum_q;
		bytes_left_d  = bytes_left_q;
		skip_left_d   = skip_left_q;
		last_chunk_d  = last_chunk_q;
		result        = '0;

		case (phase_q)
			PH_SIZE: begin
				if (in_byte == CHAR_CR) begin
					skip_left_d = SKIP_AFTER_CR;
					phase_d     = PH_SKIP;
				end else begin
					size_accum_d = {size_accum_q[SIZE_W-5:0], hex_value(in_byte)};
					if (digit_next >= (DIGIT_W+1)'(SIZE_DIGITS)) begin
						digit_count_d = '0;
						skip_left_d   = SKIP_NO_CR;
						phase_d       = PH_SKIP;
					end else begin
						digit_count_d = digit_next[DIGIT_W-1:0];
					end
				end
			end
			PH_SKIP: begin
				skip_left_d = skip_dec;
				if (skip_dec == '0) begin
					digit_count_d = '0;
					bytes_left_d  = size_accum_q;
					size_accum_d  = '0;
					if (size_accum_q == '0) begin
						last_chunk_d = 1'b1;
						skip_left_d  = SKIP_TRAILER;
						phase_d      = PH_TRAIL;
					end else begin
						last_chunk_d = 1'b0;
						phase_d      = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				result.emit  = 1'b1;
				result.data  = in_byte;
				bytes_left_d = bytes_dec;
				if (bytes_dec == '0) begin
					skip_left_d = SKIP_TRAILER;
					phase_d     = PH_TRAIL;
				end
			end
			PH_TRAIL: begin
				skip_left_d = skip_dec;
				if (skip_dec == '0) begin
					if (last_chunk_q) begin
						phase_d     = PH_DONE;
						result.emit = 1'b1;
						result.eob  = 1'b1;
					end else begin
						phase_d       = PH_SIZE;
						digit_count_d = '0;
						size_accum_d  = '0;
					end
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

endmodule

@@ rtl/chunked_body_decoder.sv @@
// Chunked message body decoder. Feed it the body bytes of a chunked message,
// one word per handshake, starting with the first byte after the header. It
// reads each chunk-size field (up to chd_pkg::SIZE_DIGITS hex characters,
// ended by a carriage return; non-hex characters count as digit zero), skips
// the line feed, or the next two bytes when no carriage return came within the
// digit limit, passes every data byte of the chunk out as one word with
// end_of_body low, and drops the two-byte chunk trailer. A chunk of size zero
// ends the body: after its trailer one word with end_of_body high and
// out_byte zero comes out, and every later input word is swallowed until
// reset. The block takes one byte per clock cycle when the output side is not
// stalled. A taken byte waits in the input register until the core steps on
// it; a byte that makes a result has its word then loaded into the output
// register, which drives out_valid and holds the word until it leaves
// downstream. Throughput is set by the single phase machine, which
// advances once per byte; the input stalls only while a byte that makes a
// result waits behind a stalled output word.
module chunked_body_decoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [chd_pkg::BYTE_W-1:0] in_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [chd_pkg::BYTE_W-1:0] out_byte,
	output logic                       end_of_body
);
	import chd_pkg::*;

	// Input register stage.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Output register.
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              eob_q;

	chd_result_t       result;
	logic              out_free;
	logic              s1_move;
	logic              in_take;

	// The output register can take a new word when it is empty or when its
	// current word leaves in this cycle.
	assign out_free = !out_valid_q || !out_stall;

	// A byte that makes no result may always move on; one that makes a
	// result waits for room in the output register.
	assign s1_move  = valid_s1 && (!result.emit || out_free);
	assign in_stall = valid_s1 && !s1_move;
	assign in_take  = in_valid && !in_stall;

	chd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (s1_move),
		.in_byte (byte_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move && result.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && result.emit) begin
			out_byte_q <= result.data;
			eob_q      <= result.eob;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign end_of_body = eob_q;

endmodule

@@ rtl/chd_checker.sv @@
module chd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic [chd_pkg::BYTE_W-1:0] in_byte,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [chd_pkg::BYTE_W-1:0] out_byte,
	input logic                       end_of_body
);
	import chd_pkg::*;

	logic done_q;

	// Set once the end word has been taken downstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (out_valid && !out_stall && end_of_body) begin
			done_q <= 1'b1;
		end
	end

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(end_of_body))
		else $error("output word changed while stalled");

	// The end word carries a zero byte.
	a_eob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_body |-> out_byte == '0)
		else $error("end word with nonzero byte");

	// Nothing comes out after the end of the body.
	a_no_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !out_valid)
		else $error("word after end of body");

	// The input side only stalls when the output side is backed up.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	logic unused_in;
	assign unused_in = in_valid ^ (^in_byte);

endmodule

bind chunked_body_decoder chd_checker u_chd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.in_byte     (in_byte),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_byte    (out_byte),
	.end_of_body (end_of_body)
);
